### rtl/mrte_pkg.sv
// Package for the mailbox RAM transfer engine: shared types, codes and constants.
// Used by mrte_cfg, mrte_step and mailbox_ram_transfer_engine_core; depends on nothing.
package mrte_pkg;

  // Item opcodes.
  typedef enum logic [2:0] {
    OP_START_READ  = 3'd0,
    OP_START_WRITE = 3'd1,
    OP_READ_IRQ    = 3'd2,
    OP_WRITE_IRQ   = 3'd3,
    OP_MCU_RESET   = 3'd4
  } opcode_e;

  // Transfer sequence phases.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CHECK  = 2'd1,
    PH_DATA   = 2'd2,
    PH_FINAL  = 2'd3
  } phase_e;

  // Completion status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_IO_ERR = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_VENDOR = 1'b0,
    CFG_ENABLE = 1'b1
  } cfg_idx_e;

  localparam logic [15:0] ErrWriteReply = 16'h0082;
  localparam logic [15:0] ErrReadReply  = 16'h0083;
  localparam logic [16:0] Win0Start     = 17'h09000;
  localparam logic [16:0] Win0End       = 17'h09FA0;
  localparam logic [16:0] Win1End       = 17'h00FFF;

  typedef struct packed {
    logic vendor_select;
    logic engine_enabled;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] start_address;
    logic [15:0] word_total;
    logic [15:0] mailbox_in1;
    logic [15:0] mailbox_in2;
    logic [15:0] mailbox_in3;
    logic [15:0] write_word0;
    logic [15:0] write_word1;
    logic [15:0] write_word2;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic        dir_write;
    logic        busy;
    logic [15:0] word_position;
    logic [15:0] length_words;
    logic [15:0] base_address;
    logic        mcu_reset_seen;
  } state_t;

  typedef struct packed {
    logic        mailbox_write;
    logic [15:0] mailbox_out1;
    logic [15:0] mailbox_out2;
    logic [15:0] mailbox_out3;
    logic [15:0] read_word0;
    logic [15:0] read_word1;
    logic [15:0] read_word2;
    logic [1:0]  words_moved;
    logic        irq_rearm;
    logic        transfer_done;
    status_e     status;
  } res_t;

endpackage

### rtl/mrte_cfg.sv
// Configuration registers of the mailbox RAM transfer engine.
// Depends on mrte_pkg for the register index codes and the cfg_t struct.
module mrte_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic          cfg_wdata_i,
  output mrte_pkg::cfg_t cfg_o
);

  logic vendor_q, vendor_d;
  logic enable_q, enable_d;

  // Register write decode.
  always_comb begin
    vendor_d = vendor_q;
    enable_d = enable_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mrte_pkg::CFG_VENDOR: vendor_d = cfg_wdata_i;
        mrte_pkg::CFG_ENABLE: enable_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The engine comes out of reset enabled, on the first silicon variant.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q <= 1'b0;
      enable_q <= 1'b1;
    end else begin
      vendor_q <= vendor_d;
      enable_q <= enable_d;
    end
  end

  assign cfg_o.vendor_select  = vendor_q;
  assign cfg_o.engine_enabled = enable_q;

endmodule

### rtl/mrte_step.sv
// Next-state and result logic for one item of the mailbox RAM transfer engine.
// Purely combinational; depends on mrte_pkg for types, codes and constants.
module mrte_step (
  input  mrte_pkg::cfg_t   cfg_i,
  input  mrte_pkg::state_t state_i,
  input  mrte_pkg::item_t  item_i,
  output mrte_pkg::state_t state_o,
  output mrte_pkg::res_t   res_o
);

  logic [16:0] end_sum;
  logic        window_ok;
  logic        start_ok;
  logic [15:0] pos1, pos2, pos3;
  logic        take1, take2;
  logic [1:0]  moved;
  logic [15:0] new_pos;
  logic        read_err, write_err;

  // Address window of the selected variant; the end is taken at 17 bits.
  assign end_sum   = {1'b0, item_i.start_address} + {1'b0, item_i.word_total};
  assign window_ok = cfg_i.vendor_select ? (end_sum <= mrte_pkg::Win1End)
                   : (({1'b0, item_i.start_address} >= mrte_pkg::Win0Start) &&
                      (end_sum <= mrte_pkg::Win0End));
  assign start_ok  = cfg_i.engine_enabled && !state_i.busy && !state_i.mcu_reset_seen &&
                     (item_i.word_total != 16'd0) && window_ok;

  // Up to three words per event, stopping at the end of the block.
  assign pos1    = state_i.word_position + 16'd1;
  assign pos2    = state_i.word_position + 16'd2;
  assign pos3    = state_i.word_position + 16'd3;
  assign take1   = (pos1 != state_i.length_words);
  assign take2   = take1 && (pos2 != state_i.length_words);
  assign moved   = take2 ? 2'd3 : (take1 ? 2'd2 : 2'd1);
  assign new_pos = take2 ? pos3 : (take1 ? pos2 : pos1);

  assign read_err  = (item_i.mailbox_in1 == mrte_pkg::ErrReadReply);
  assign write_err = (item_i.mailbox_in1 == mrte_pkg::ErrWriteReply);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    res_o.status = mrte_pkg::ST_OK;

    unique case (item_i.opcode)
      mrte_pkg::OP_START_READ, mrte_pkg::OP_START_WRITE: begin
        if (start_ok) begin
          state_o.base_address  = item_i.start_address;
          state_o.length_words  = item_i.word_total;
          state_o.dir_write     = item_i.opcode[0];
          state_o.phase         = mrte_pkg::PH_HEADER;
          state_o.word_position = 16'd0;
          state_o.busy          = 1'b1;
          res_o.irq_rearm       = 1'b1;
        end else begin
          res_o.transfer_done = 1'b1;
          res_o.status        = mrte_pkg::ST_REJECT;
        end
      end

      // Read interrupt: header, optional error check, data, final check.
      mrte_pkg::OP_READ_IRQ: begin
        if (state_i.busy && !state_i.dir_write) begin
          unique case (state_i.phase)
            mrte_pkg::PH_HEADER: begin
              res_o.mailbox_write = 1'b1;
              res_o.mailbox_out1  = state_i.base_address;
              res_o.mailbox_out2  = state_i.length_words;
              res_o.irq_rearm     = 1'b1;
              state_o.phase = cfg_i.vendor_select ? mrte_pkg::PH_CHECK : mrte_pkg::PH_DATA;
            end
            mrte_pkg::PH_CHECK: begin
              if (read_err) begin
                res_o.transfer_done   = 1'b1;
                res_o.status          = mrte_pkg::ST_IO_ERR;
                state_o.busy          = 1'b0;
                state_o.phase         = mrte_pkg::PH_HEADER;
                state_o.word_position = 16'd0;
              end else begin
                state_o.phase   = mrte_pkg::PH_DATA;
                res_o.irq_rearm = 1'b1;
              end
            end
            mrte_pkg::PH_DATA: begin
              res_o.read_word0  = item_i.mailbox_in1;
              res_o.read_word1  = take1 ? item_i.mailbox_in2 : 16'd0;
              res_o.read_word2  = take2 ? item_i.mailbox_in3 : 16'd0;
              res_o.words_moved = moved;
              res_o.irq_rearm   = 1'b1;
              state_o.word_position = new_pos;
              if (new_pos == state_i.length_words) begin
                state_o.phase = mrte_pkg::PH_FINAL;
              end
            end
            default: begin
              res_o.transfer_done   = 1'b1;
              res_o.status          = read_err ? mrte_pkg::ST_IO_ERR : mrte_pkg::ST_OK;
              state_o.busy          = 1'b0;
              state_o.phase         = mrte_pkg::PH_HEADER;
              state_o.word_position = 16'd0;
            end
          endcase
        end
      end

      // Write interrupt: a clean check reply falls straight into the data phase.
      mrte_pkg::OP_WRITE_IRQ: begin
        if (state_i.busy && state_i.dir_write) begin
          if (state_i.phase == mrte_pkg::PH_HEADER) begin
            res_o.mailbox_write = 1'b1;
            res_o.mailbox_out1  = state_i.base_address;
            res_o.mailbox_out2  = state_i.length_words;
            res_o.irq_rearm     = 1'b1;
            state_o.phase       = mrte_pkg::PH_CHECK;
          end else if ((state_i.phase == mrte_pkg::PH_CHECK && !write_err) ||
                       state_i.phase == mrte_pkg::PH_DATA) begin
            res_o.mailbox_write = 1'b1;
            res_o.mailbox_out1  = item_i.write_word0;
            res_o.mailbox_out2  = take1 ? item_i.write_word1 : 16'd0;
            res_o.mailbox_out3  = take2 ? item_i.write_word2 : 16'd0;
            res_o.words_moved   = moved;
            res_o.irq_rearm     = 1'b1;
            state_o.word_position = new_pos;
            state_o.phase = (new_pos == state_i.length_words) ? mrte_pkg::PH_FINAL
                                                              : mrte_pkg::PH_DATA;
          end else begin
            res_o.transfer_done   = 1'b1;
            res_o.status          = write_err ? mrte_pkg::ST_IO_ERR : mrte_pkg::ST_OK;
            state_o.busy          = 1'b0;
            state_o.phase         = mrte_pkg::PH_HEADER;
            state_o.word_position = 16'd0;
          end
        end
      end

      // Microcontroller reset aborts any transfer and blocks later starts.
      mrte_pkg::OP_MCU_RESET: begin
        state_o.mcu_reset_seen = 1'b1;
        state_o.busy           = 1'b0;
        state_o.phase          = mrte_pkg::PH_HEADER;
        state_o.word_position  = 16'd0;
        res_o.transfer_done    = 1'b1;
        res_o.status           = mrte_pkg::ST_IO_ERR;
      end

      default: ;
    endcase
  end

endmodule

### rtl/mailbox_ram_transfer_engine_core.sv
// Top level of the mailbox RAM transfer engine: input register, transfer state,
// result register and handshakes. Depends on mrte_pkg, mrte_cfg and mrte_step.
//
// Every input item (start, interrupt event or microcontroller reset) produces
// exactly one result item. The engine takes one item per clock cycle unless the
// result channel stalls. The accepting edge loads the input register; the item then
// passes through the single step of decision logic into the result register once
// that register is free or draining. The input register keeps taking items while a
// result waits to be taken, so a stalled consumer costs one slot of buffering before
// in_ready_o drops. Configuration registers take effect for items accepted after the
// write; write them only while no item is in flight.
module mailbox_ram_transfer_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i,
  // Input item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] word_total_i,
  input  logic [15:0] mailbox_in1_i,
  input  logic [15:0] mailbox_in2_i,
  input  logic [15:0] mailbox_in3_i,
  input  logic [15:0] write_word0_i,
  input  logic [15:0] write_word1_i,
  input  logic [15:0] write_word2_i,
  // Result item channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        mailbox_write_o,
  output logic [15:0] mailbox_out1_o,
  output logic [15:0] mailbox_out2_o,
  output logic [15:0] mailbox_out3_o,
  output logic [15:0] read_word0_o,
  output logic [15:0] read_word1_o,
  output logic [15:0] read_word2_o,
  output logic [1:0]  words_moved_o,
  output logic        irq_rearm_o,
  output logic        transfer_done_o,
  output logic [1:0]  status_o
);

  mrte_pkg::cfg_t   cfg;
  mrte_pkg::item_t  item_q;
  mrte_pkg::state_t state_q, state_d, step_state;
  mrte_pkg::res_t   res_q, step_res;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             in_fire;
  logic             step_fire;

  mrte_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mrte_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (step_state),
    .res_o   (step_res)
  );

  // Handshakes: the held item steps when the result register is free or draining.
  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Transfer state advances only when an item is processed.
  assign state_d = step_fire ? step_state : state_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.opcode        <= opcode_i;
      item_q.start_address <= start_address_i;
      item_q.word_total    <= word_total_i;
      item_q.mailbox_in1   <= mailbox_in1_i;
      item_q.mailbox_in2   <= mailbox_in2_i;
      item_q.mailbox_in3   <= mailbox_in3_i;
      item_q.write_word0   <= write_word0_i;
      item_q.write_word1   <= write_word1_i;
      item_q.write_word2   <= write_word2_i;
    end
  end

  // Transfer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: mrte_pkg::PH_HEADER, dir_write: 1'b0, busy: 1'b0,
                   word_position: 16'd0, length_words: 16'd0, base_address: 16'd0,
                   mcu_reset_seen: 1'b0};
    end else begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mailbox_write_o = res_q.mailbox_write;
  assign mailbox_out1_o  = res_q.mailbox_out1;
  assign mailbox_out2_o  = res_q.mailbox_out2;
  assign mailbox_out3_o  = res_q.mailbox_out3;
  assign read_word0_o    = res_q.read_word0;
  assign read_word1_o    = res_q.read_word1;
  assign read_word2_o    = res_q.read_word2;
  assign words_moved_o   = res_q.words_moved;
  assign irq_rearm_o     = res_q.irq_rearm;
  assign transfer_done_o = res_q.transfer_done;
  assign status_o        = res_q.status;

  // An idle engine sits at the header phase with its position cleared.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.busy |-> (state_q.phase == mrte_pkg::PH_HEADER) &&
                      (state_q.word_position == 16'd0))
    else $error("idle engine holds stale phase or position");

  // An active transfer always has a nonzero length and never runs past it.
  a_busy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.busy |-> (state_q.length_words != 16'd0) &&
                     (state_q.word_position <= state_q.length_words))
    else $error("active transfer with bad length or position");

  // A finished or aborted transfer leaves the engine idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && step_res.transfer_done && (step_res.status != mrte_pkg::ST_REJECT)
      |=> !state_q.busy)
    else $error("engine still busy after completion");

  // Data movement always comes with the interrupt being rearmed.
  a_move_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.words_moved != 2'd0) |-> res_q.irq_rearm && !res_q.transfer_done)
    else $error("words moved without rearm");

  // Once a microcontroller reset is seen, no start can succeed.
  a_reset_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mcu_reset_seen |=> !$rose(state_q.busy))
    else $error("start accepted after microcontroller reset");

endmodule
